>>> src/clcg_pkg.sv
// Package with the constants, types and modular step function of the combined LCG.
package clcg_pkg;

   localparam logic ACTION_DRAW = 1'b0;
   localparam logic ACTION_LOAD = 1'b1;

   localparam logic [15:0] MUL_FIRST  = 16'd40014;
   localparam logic [30:0] MOD_FIRST  = 31'd2147483563;
   localparam logic [7:0]  FOLD_FIRST = 8'd85;
   localparam logic [15:0] MUL_SECOND  = 16'd40692;
   localparam logic [30:0] MOD_SECOND  = 31'd2147483399;
   localparam logic [7:0]  FOLD_SECOND = 8'd249;

   localparam logic [31:0] SUB_FIRST  = 32'd954837833;
   localparam logic [31:0] SUB_SECOND = 32'd3987583;
   localparam logic [31:0] DEF_FIRST  = 32'd398745;
   localparam logic [31:0] DEF_SECOND = 32'd3987583;

   typedef struct packed {
      logic        load;
      logic [31:0] first_seed;
      logic [31:0] second_seed;
   } stage_type;

   // The modulus is 2^31 - fold, so the upper product bits fold back as a small multiple.
   function automatic logic [30:0] mod_step(logic [31:0] seed, logic [15:0] mul,
                                            logic [30:0] modulus, logic [7:0] fold);
      logic [47:0] prod;
      logic [31:0] sum;
      prod = {16'd0, seed} * {32'd0, mul};
      sum = {1'b0, prod[30:0]} + ({15'd0, prod[47:31]} * {24'd0, fold});
      if (sum >= {1'b0, modulus}) begin
         sum = sum - {1'b0, modulus};
      end
      return sum[30:0];
   endfunction

endpackage

>>> src/clcg_seed_unit.sv
// Seed state registers with the load and draw update of both generators.
module clcg_seed_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                action,
   input  logic [31:0]         first_seed_in,
   input  logic [31:0]         second_seed_in,
   output clcg_pkg::stage_type stage
);

   logic [31:0] first_seed_ff, first_seed_in_next;
   logic [31:0] second_seed_ff, second_seed_in_next;
   logic        load_ff, load_in;
   logic [31:0] base_first, base_second;

   always_comb begin
      base_first  = first_seed_ff;
      base_second = second_seed_ff;
      if (second_seed_ff == 32'd0) begin
         base_first  = clcg_pkg::DEF_FIRST;
         base_second = clcg_pkg::DEF_SECOND;
      end
      if (action == clcg_pkg::ACTION_LOAD) begin
         load_in = 1'b1;
         first_seed_in_next  = (first_seed_in == 32'd0) ? clcg_pkg::SUB_FIRST : first_seed_in;
         second_seed_in_next = (second_seed_in == 32'd0) ? clcg_pkg::SUB_SECOND
                                                         : second_seed_in;
      end else begin
         load_in = 1'b0;
         first_seed_in_next = {1'b0, clcg_pkg::mod_step(base_first, clcg_pkg::MUL_FIRST,
                                     clcg_pkg::MOD_FIRST, clcg_pkg::FOLD_FIRST)};
         second_seed_in_next = {1'b0, clcg_pkg::mod_step(base_second, clcg_pkg::MUL_SECOND,
                                      clcg_pkg::MOD_SECOND, clcg_pkg::FOLD_SECOND)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seed_ff  <= 32'd0;
         second_seed_ff <= 32'd0;
      end else if (enable) begin
         first_seed_ff  <= first_seed_in_next;
         second_seed_ff <= second_seed_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         load_ff <= load_in;
      end
   end

   assign stage.load        = load_ff;
   assign stage.first_seed  = first_seed_ff;
   assign stage.second_seed = second_seed_ff;

endmodule

>>> src/clcg_combine.sv
// Pipeline stage that sums both seeds with a wrap at the first modulus.
module clcg_combine (
   input  logic                clock,
   input  logic                enable,
   input  clcg_pkg::stage_type stage_in,
   output clcg_pkg::stage_type stage_out,
   output logic [30:0]         sum
);

   clcg_pkg::stage_type stage_ff;
   logic [30:0]         sum_ff, sum_in;
   logic [31:0]         raw;

   always_comb begin
      raw = {1'b0, stage_in.first_seed[30:0]} + {1'b0, stage_in.second_seed[30:0]};
      if (raw >= {1'b0, clcg_pkg::MOD_FIRST}) begin
         raw = raw - {1'b0, clcg_pkg::MOD_FIRST};
      end
      sum_in = raw[30:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
         sum_ff   <= sum_in;
      end
   end

   assign stage_out = stage_ff;
   assign sum       = sum_ff;

endmodule

>>> src/clcg_frac.sv
// Result stage that forms the 0.32 fraction and holds the result registers.
module clcg_frac (
   input  logic                clock,
   input  logic                enable,
   input  clcg_pkg::stage_type stage_in,
   input  logic [30:0]         sum,
   output logic [30:0]         value,
   output logic [31:0]         fraction,
   output logic [31:0]         first_seed_now,
   output logic [31:0]         second_seed_now
);

   logic [30:0] value_ff, value_in;
   logic [31:0] fraction_ff, fraction_in;
   logic [31:0] first_ff, second_ff;
   logic [38:0] scaled;
   logic [7:0]  quot;
   logic [31:0] rem;

   // Since 2^32 = 2 * (M + 85), the fraction is 2z + floor(170z / M).
   always_comb begin
      scaled = {8'd0, sum} * 39'd170;
      rem = {1'b0, scaled[30:0]} + ({24'd0, scaled[38:31]} * {24'd0, clcg_pkg::FOLD_FIRST});
      quot = scaled[38:31];
      if (rem >= {1'b0, clcg_pkg::MOD_FIRST}) begin
         quot = quot + 8'd1;
      end
      if (stage_in.load) begin
         value_in    = 31'd0;
         fraction_in = 32'd0;
      end else begin
         value_in    = sum;
         fraction_in = {sum, 1'b0} + {24'd0, quot};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff    <= value_in;
         fraction_ff <= fraction_in;
         first_ff    <= stage_in.first_seed;
         second_ff   <= stage_in.second_seed;
      end
   end

   assign value           = value_ff;
   assign fraction        = fraction_ff;
   assign first_seed_now  = first_ff;
   assign second_seed_now = second_ff;

endmodule

>>> src/combined_lcg_random_generator_top.sv
// Top level of the combined two-generator multiplicative random source.
//
// Each request transaction either draws the next number (action 0) or loads
// both seeds (action 1); every request yields exactly one response transaction.
// A response carries the combined value, its 0.32 fraction of the first modulus,
// and both seeds as they stand after the request. A load returns zero value and
// fraction.
// The block is a three-stage pipeline: the seed registers update in the cycle of
// acceptance, the next stage sums the seeds, the last forms the fraction. A
// response is valid once its request has passed the sum and fraction stages, and
// one request can be accepted in every cycle while no valid response is stalled.
// The seed update loop (a 32 by 16 constant multiply and reduction) sets that rate.
// Reset clears both seeds, so the first draw reloads the default seeds. While
// the receiver stalls a valid response, the whole pipeline holds and req_ready
// is low; it accepts again in the cycle the response is taken.
module combined_lcg_random_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_first_seed_in,
   input  logic [31:0] req_second_seed_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_value,
   output logic [31:0] rsp_fraction,
   output logic [31:0] rsp_first_seed_now,
   output logic [31:0] rsp_second_seed_now
);

   logic                advance;
   logic                accept;
   logic                seed_valid_ff, sum_valid_ff, rsp_valid_ff;
   clcg_pkg::stage_type seed_stage, sum_stage;
   logic [30:0]         sum;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && advance;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         seed_valid_ff <= req_valid;
         sum_valid_ff  <= seed_valid_ff;
         rsp_valid_ff  <= sum_valid_ff;
      end
   end

   clcg_seed_unit u_seed (
      .clock          (clock),
      .reset          (reset),
      .enable         (accept),
      .action         (req_action),
      .first_seed_in  (req_first_seed_in),
      .second_seed_in (req_second_seed_in),
      .stage          (seed_stage)
   );

   clcg_combine u_combine (
      .clock     (clock),
      .enable    (advance),
      .stage_in  (seed_stage),
      .stage_out (sum_stage),
      .sum       (sum)
   );

   clcg_frac u_frac (
      .clock           (clock),
      .enable          (advance),
      .stage_in        (sum_stage),
      .sum             (sum),
      .value           (rsp_value),
      .fraction        (rsp_fraction),
      .first_seed_now  (rsp_first_seed_now),
      .second_seed_now (rsp_second_seed_now)
   );

endmodule

>>> tb/combined_lcg_random_generator_top_tb.sv
// Self-checking testbench for the combined two-generator multiplicative random source.
module combined_lcg_random_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] GEN0_MUL = 64'd40014;
   localparam logic [63:0] GEN0_MOD = 64'd2147483563;
   localparam logic [63:0] GEN1_MUL = 64'd40692;
   localparam logic [63:0] GEN1_MOD = 64'd2147483399;
   localparam logic [31:0] GEN0_SUB = 32'd954837833;
   localparam logic [31:0] GEN1_SUB = 32'd3987583;
   localparam logic [31:0] GEN0_DEF = 32'd398745;
   localparam logic [31:0] GEN1_DEF = 32'd3987583;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS = 250;
   localparam int PHASE_TOTAL = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [30:0] value;
      logic [31:0] fraction;
      logic [31:0] first_seed;
      logic [31:0] second_seed;
   } draw_result_type;

   class draw_scoreboard;
      logic [31:0] first_seed;
      logic [31:0] second_seed;
      draw_result_type draws_in_flight[$];
      int errors;
      int responses;
      int draws;
      int loads;
      int reloads;

      function new();
         first_seed = 32'd0;
         second_seed = 32'd0;
         errors = 0;
         responses = 0;
         draws = 0;
         loads = 0;
         reloads = 0;
      endfunction

      function int pending();
         return draws_in_flight.size();
      endfunction

      function void note_request(logic action, logic [31:0] first_in, logic [31:0] second_in);
         draw_result_type item;
         logic [63:0] sum;
         item = '0;
         if (action == clcg_pkg::ACTION_LOAD) begin
            loads++;
            first_seed = (first_in == 32'd0) ? GEN0_SUB : first_in;
            second_seed = (second_in == 32'd0) ? GEN1_SUB : second_in;
         end else begin
            draws++;
            if (second_seed == 32'd0) begin
               reloads++;
               first_seed = GEN0_DEF;
               second_seed = GEN1_DEF;
            end
            first_seed = 32'(({32'd0, first_seed} * GEN0_MUL) % GEN0_MOD);
            second_seed = 32'(({32'd0, second_seed} * GEN1_MUL) % GEN1_MOD);
            sum = {32'd0, first_seed} + {32'd0, second_seed};
            if (sum >= GEN0_MOD) begin
               sum = sum - GEN0_MOD;
            end
            item.value = sum[30:0];
            item.fraction = 32'((sum << 32) / GEN0_MOD);
         end
         item.first_seed = first_seed;
         item.second_seed = second_seed;
         draws_in_flight.push_back(item);
      endfunction

      function void mismatch(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("ERROR: response %0d, %s expected %h, actual %h",
                     responses, field, want, got);
         end
      endfunction

      function void check_response(logic [30:0] value, logic [31:0] fraction,
                                   logic [31:0] first_now, logic [31:0] second_now);
         draw_result_type want;
         responses++;
         if (draws_in_flight.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("ERROR: response %0d arrived with no request outstanding (value %h)",
                        responses, value);
            end
            return;
         end
         want = draws_in_flight.pop_front();
         if (value != want.value) mismatch("value", {1'b0, want.value}, {1'b0, value});
         if (fraction != want.fraction) mismatch("fraction", want.fraction, fraction);
         if (first_now != want.first_seed) mismatch("first seed", want.first_seed, first_now);
         if (second_now != want.second_seed) mismatch("second seed", want.second_seed, second_now);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = clcg_pkg::ACTION_DRAW;
   logic [31:0] req_first_seed_in = 32'd0;
   logic [31:0] req_second_seed_in = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [30:0] rsp_value;
   logic [31:0] rsp_fraction;
   logic [31:0] rsp_first_seed_now;
   logic [31:0] rsp_second_seed_now;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   draw_scoreboard board;

   combined_lcg_random_generator_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_first_seed_in   (req_first_seed_in),
      .req_second_seed_in  (req_second_seed_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_value           (rsp_value),
      .rsp_fraction        (rsp_fraction),
      .rsp_first_seed_now  (rsp_first_seed_now),
      .rsp_second_seed_now (rsp_second_seed_now)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_value, rsp_fraction, rsp_first_seed_now,
                                 rsp_second_seed_now);
         end
         if (req_valid && req_ready) begin
            board.note_request(req_action, req_first_seed_in, req_second_seed_in);
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [31:0] pick_seed(logic [31:0] modulus);
      case ($urandom_range(9))
         0: return 32'd0;
         1: return modulus;
         2: return modulus - 32'd1;
         3: return modulus + 32'd1;
         4: return 32'hFFFF_FFFF;
         5: return 32'($urandom_range(1, 1000));
         6: return 32'(2 * GEN1_MOD);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(logic action, logic [31:0] first_in, logic [31:0] second_in);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_first_seed_in <= first_in;
      req_second_seed_in <= second_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int phase;
      int k;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_stall_pct = 6;
      send_request(clcg_pkg::ACTION_DRAW, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(clcg_pkg::ACTION_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(clcg_pkg::ACTION_LOAD, 32'd0, 32'd0);
      send_request(clcg_pkg::ACTION_DRAW, 32'd0, 32'd0);
      send_request(clcg_pkg::ACTION_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(clcg_pkg::ACTION_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(clcg_pkg::ACTION_DRAW, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(clcg_pkg::ACTION_LOAD, GEN0_MOD[31:0], GEN1_MOD[31:0]);
      send_request(clcg_pkg::ACTION_DRAW, 32'd0, 32'd0);
      send_request(clcg_pkg::ACTION_DRAW, 32'd0, 32'd0);
      send_request(clcg_pkg::ACTION_LOAD, 32'd1, 32'(2 * GEN1_MOD));
      send_request(clcg_pkg::ACTION_DRAW, 32'd0, 32'd0);
      send_request(clcg_pkg::ACTION_LOAD, 32'd0, 32'd5);
      send_request(clcg_pkg::ACTION_LOAD, 32'd7, 32'd0);
      send_request(clcg_pkg::ACTION_DRAW, 32'd0, 32'd0);
      send_request(clcg_pkg::ACTION_LOAD, GEN0_MOD[31:0] - 32'd1, GEN1_MOD[31:0] - 32'd1);
      send_request(clcg_pkg::ACTION_DRAW, 32'd0, 32'd0);
      send_request(clcg_pkg::ACTION_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(clcg_pkg::ACTION_DRAW, 32'd0, 32'd0);
      send_request(clcg_pkg::ACTION_DRAW, 32'd0, 32'd0);

      for (phase = 0; phase < PHASE_TOTAL; phase++) begin
         pause_until_drained();
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 87;
            end
            default: begin
               send_idle_pct = 6;
               recv_stall_pct = 6;
            end
         endcase
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(4) == 0) begin
               send_request(clcg_pkg::ACTION_LOAD, pick_seed(GEN0_MOD[31:0]),
                            pick_seed(GEN1_MOD[31:0]));
            end else begin
               send_request(clcg_pkg::ACTION_DRAW, $urandom, $urandom);
            end
         end
      end

      pause_until_drained();
      repeat (20) @(posedge clock);

      $display("Covered %0d requests: %0d draws (%0d with default reload) and %0d loads.",
               board.draws + board.loads, board.draws, board.reloads, board.loads);
      $display("Checked %0d responses under four idling profiles; %0d errors found.",
               board.responses, board.errors);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
